// ----- design/rsi_pkg.sv -----
// Shared types and constants for the ray/sphere intersection pipeline.
package rsi_pkg;

   // defaults for the top-level parameters
   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_COORD_WIDTH = 32;

   // a, q, c are held signed and saturated to +-(2^62 - 1)
   localparam int MID_W = 63;
   localparam logic signed [MID_W-1:0] MID_MAX = {1'b0, {(MID_W-1){1'b1}}};

   // magnitude split for the products of 62-bit magnitudes
   localparam int MAG_W = MID_W - 1;
   localparam int LO_W  = 32;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int PP_W  = 2 * MAG_W;

   // discriminant, its root and the root-adjusted numerator
   localparam int H_W    = 2 * MID_W;
   localparam int ROOT_W = H_W / 2;
   localparam int NUM_W  = MID_W + 2;
   localparam int MAGN_W = NUM_W - 1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPHERE_RADIUS = 2'd3;

   // control that travels with each word between pipeline sections
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

endpackage

// ----- design/rsi_ifs.sv -----
// Handshake channels of the ray/sphere intersection block.
interface rsi_req_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface rsi_rsp_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic hit;
   logic signed [COORD_WIDTH-1:0] hit_distance;
   logic signed [COORD_WIDTH-1:0] impact_x;
   logic signed [COORD_WIDTH-1:0] impact_y;
   logic signed [COORD_WIDTH-1:0] impact_z;
   modport source (output valid, hit, hit_distance, impact_x, impact_y, impact_z,
                   input ready);
   modport sink (input valid, hit, hit_distance, impact_x, impact_y, impact_z,
                 output ready);
endinterface

interface rsi_csr_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic [rsi_pkg::CSR_IDX_W-1:0] index;
   logic [COORD_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/ray_sphere_intersection_top.sv -----
// Top level of the ray/sphere intersection pipeline.
//
// Usage: write the sphere center and radius on csr_bus (always ready) while
// the block is idle. Send rays on req_bus, one word per cycle; each ray gives
// exactly one word on rsp_bus: hit flag, distance t and impact point, all
// signed fixed point with FRAC_BITS fraction bits, zeros on a miss.
// Stages in order: quadratic terms, discriminant, bit-per-stage square root,
// root selection, bit-per-stage divider, then saturation, impact point and
// the output register.
// Throughput is one ray per cycle while not frozen. The whole pipeline moves
// as one; it freezes only when a result sits in the output register and
// rsp_bus.ready is low, and req_bus.ready follows that condition.
// Reset clears all valid bits and the configuration registers; no word is
// lost or repeated across a stall.
module ray_sphere_intersection_top #(
   parameter int FRAC_BITS   = rsi_pkg::DEF_FRAC_BITS,
   parameter int COORD_WIDTH = rsi_pkg::DEF_COORD_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   rsi_csr_if.sink    csr_bus,
   rsi_req_if.sink    req_bus,
   rsi_rsp_if.source  rsp_bus
);
   import rsi_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int VEC_W  = 3 * CW;
   localparam int SIDE_D = 2 * VEC_W;
   localparam int SIDE_Q = SIDE_D + 2 * MID_W;
   localparam int PROD_W = 2 * CW;
   localparam int IMP_W  = 2 * CW + 1;
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW:0]          HALF      = (CW+1)'(1) << (CW - 1);

   logic en;

   // configuration registers
   logic [2:0][CW-1:0] center_ff;
   logic [CW-2:0]      radius_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_CENTER_X:      center_ff[0] <= csr_bus.data;
            REG_CENTER_Y:      center_ff[1] <= csr_bus.data;
            REG_CENTER_Z:      center_ff[2] <= csr_bus.data;
            REG_SPHERE_RADIUS: radius_ff    <= csr_bus.data[CW-2:0];
            default:           radius_ff    <= radius_ff;
         endcase
      end
   end

   // pipeline advance: output register empty or being taken
   logic out_v_ff;
   assign en            = rsp_bus.ready | ~out_v_ff;
   assign req_bus.ready = en;

   // quadratic terms
   ctl_type                 quad_ctl;
   logic signed [MID_W-1:0] quad_a, quad_q, quad_c;
   logic [2:0][CW-1:0]      quad_o, quad_d;

   rsi_quad #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_quad (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_bus.valid),
      .origin     ({req_bus.origin_z, req_bus.origin_y, req_bus.origin_x}),
      .dir        ({req_bus.dir_z, req_bus.dir_y, req_bus.dir_x}),
      .center     (center_ff),
      .radius     (radius_ff),
      .ctl_out    (quad_ctl),
      .a_out      (quad_a),
      .q_out      (quad_q),
      .c_out      (quad_c),
      .origin_out (quad_o),
      .dir_out    (quad_d)
   );

   // discriminant
   ctl_type            disc_ctl;
   logic [H_W-1:0]     disc_h;
   logic [SIDE_Q-1:0]  disc_side;

   rsi_disc #(.SIDE_W(SIDE_Q)) u_disc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (quad_ctl),
      .a_in     (quad_a),
      .q_in     (quad_q),
      .c_in     (quad_c),
      .side_in  ({quad_a, quad_q, quad_o, quad_d}),
      .ctl_out  (disc_ctl),
      .h_out    (disc_h),
      .side_out (disc_side)
   );

   // square root of the discriminant
   ctl_type             sqrt_ctl;
   logic [ROOT_W-1:0]   sqrt_root;
   logic [SIDE_Q-1:0]   sqrt_side;

   rsi_sqrt #(.SIDE_W(SIDE_Q)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (disc_ctl),
      .h_in     (disc_h),
      .side_in  (disc_side),
      .ctl_out  (sqrt_ctl),
      .root_out (sqrt_root),
      .side_out (sqrt_side)
   );

   // root choice and division
   ctl_type             div_ctl;
   logic [CW-1:0]       div_quot;
   logic                div_inexact, div_ovf, div_neg;
   logic [SIDE_D-1:0]   div_side;

   rsi_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW), .SIDE_W(SIDE_D)) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ctl_in      (sqrt_ctl),
      .q_in        (sqrt_side[SIDE_D +: MID_W]),
      .a_in        (sqrt_side[SIDE_D + MID_W +: MID_W]),
      .root_in     (sqrt_root),
      .side_in     (sqrt_side[SIDE_D-1:0]),
      .ctl_out     (div_ctl),
      .quot_out    (div_quot),
      .inexact_out (div_inexact),
      .ovf_out     (div_ovf),
      .neg_out     (div_neg),
      .side_out    (div_side)
   );

   // stage S: signed t, saturated
   logic                v_s_ff, hit_s_ff, neg_s_ff;
   logic signed [CW-1:0] ts_ff, ts_in;
   logic [2:0][CW-1:0]  o_s_ff, d_s_ff;
   logic [CW:0]         val;

   always_comb begin
      val = (CW+1)'(div_quot) + (CW+1)'(div_neg & div_inexact);
      if (!div_neg) begin
         ts_in = (div_ovf | div_quot[CW-1]) ? COORD_MAX : div_quot;
      end else begin
         ts_in = (div_ovf | (val > HALF)) ? COORD_MIN : CW'(-val);
      end
   end

   // stage M: t times direction
   logic                    v_m_ff, hit_m_ff;
   logic signed [CW-1:0]    ts_m_ff;
   logic [2:0][CW-1:0]      o_m_ff;
   logic signed [PROD_W-1:0] prod_ff [3];

   // stage F: impact point into the output register
   logic                    hit_ff;
   logic signed [CW-1:0]    dist_ff;
   logic signed [CW-1:0]    imp_ff [3];
   logic signed [CW-1:0]    imp_in [3];

   always_comb begin
      logic signed [IMP_W-1:0] p;
      for (int i = 0; i < 3; i++) begin
         p = IMP_W'(prod_ff[i] >>> FRAC_BITS) + IMP_W'($signed(o_m_ff[i]));
         if (p > IMP_W'(COORD_MAX)) begin
            imp_in[i] = COORD_MAX;
         end else if (p < IMP_W'(COORD_MIN)) begin
            imp_in[i] = COORD_MIN;
         end else begin
            imp_in[i] = CW'(p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s_ff   <= 1'b0;
         v_m_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_s_ff   <= div_ctl.valid;
         v_m_ff   <= v_s_ff;
         out_v_ff <= v_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_s_ff <= div_ctl.hit;
         neg_s_ff <= div_neg;
         ts_ff    <= ts_in;
         o_s_ff   <= div_side[SIDE_D-1:VEC_W];
         d_s_ff   <= div_side[VEC_W-1:0];
         hit_m_ff <= hit_s_ff;
         ts_m_ff  <= ts_ff;
         o_m_ff   <= o_s_ff;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= PROD_W'(ts_ff) * PROD_W'($signed(d_s_ff[i]));
         end
         hit_ff  <= hit_m_ff;
         dist_ff <= hit_m_ff ? ts_m_ff : '0;
         for (int i = 0; i < 3; i++) begin
            imp_ff[i] <= hit_m_ff ? imp_in[i] : '0;
         end
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.hit          = hit_ff;
   assign rsp_bus.hit_distance = dist_ff;
   assign rsp_bus.impact_x     = imp_ff[0];
   assign rsp_bus.impact_y     = imp_ff[1];
   assign rsp_bus.impact_z     = imp_ff[2];

   // a miss carries an all-zero word
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |->
         rsp_bus.hit_distance == '0 && rsp_bus.impact_x == '0 &&
         rsp_bus.impact_y == '0 && rsp_bus.impact_z == '0)
      else $error("miss word is not zero");

   // the chosen t keeps the sign of its numerator through saturation
   a_t_sign : assert property (@(posedge clock) disable iff (reset)
      v_s_ff && hit_s_ff |-> ts_ff[CW-1] == neg_s_ff)
      else $error("saturated t has wrong sign");

   // nothing leaves the block right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

// ----- design/rsi_quad.sv -----
// Quadratic terms a = d.d, q = oc.d, c = oc.oc - r*r, four register stages.
module rsi_quad #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [2:0][COORD_WIDTH-1:0]       origin,
   input  logic [2:0][COORD_WIDTH-1:0]       dir,
   input  logic [2:0][COORD_WIDTH-1:0]       center,
   input  logic [COORD_WIDTH-2:0]            radius,
   output rsi_pkg::ctl_type                  ctl_out,
   output logic signed [rsi_pkg::MID_W-1:0]  a_out,
   output logic signed [rsi_pkg::MID_W-1:0]  q_out,
   output logic signed [rsi_pkg::MID_W-1:0]  c_out,
   output logic [2:0][COORD_WIDTH-1:0]       origin_out,
   output logic [2:0][COORD_WIDTH-1:0]       dir_out
);
   import rsi_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int OC_W  = CW + 1;
   localparam int DD_W  = 2 * CW;
   localparam int OD_W  = 2 * CW + 1;
   localparam int OO_W  = 2 * CW + 2;
   localparam int RR_W  = 2 * CW - 2;
   localparam int SUM_W = 2 * CW + 4;
   localparam int SH_W  = SUM_W - FRAC_BITS;
   localparam int CMP_W = (SH_W > MID_W) ? SH_W : MID_W;
   localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(MID_MAX);

   function automatic logic signed [MID_W-1:0] sat_mid(input logic signed [CMP_W-1:0] x);
      logic signed [MID_W-1:0] r;
      if (x > SAT_HI) begin
         r = MID_MAX;
      end else if (x < -SAT_HI) begin
         r = -MID_MAX;
      end else begin
         r = MID_W'(x);
      end
      return r;
   endfunction

   logic [3:0]                 v_ff;
   logic [2:0][CW-1:0]         o_ff [4];
   logic [2:0][CW-1:0]         d_ff [4];
   logic [CW-2:0]              r_ff;
   logic signed [OC_W-1:0]     oc_ff [3];
   logic signed [OC_W-1:0]     oc_in [3];
   logic signed [DD_W-1:0]     dd_ff [3];
   logic signed [DD_W-1:0]     dd_in [3];
   logic signed [OD_W-1:0]     od_ff [3];
   logic signed [OD_W-1:0]     od_in [3];
   logic signed [OO_W-1:0]     oo_ff [3];
   logic signed [OO_W-1:0]     oo_in [3];
   logic [RR_W-1:0]            rr_ff;
   logic [RR_W-1:0]            rr_in;
   logic signed [SUM_W-1:0]    sa_ff, sq_ff, sc_ff;
   logic signed [SUM_W-1:0]    sa_in, sq_in, sc_in;
   logic signed [MID_W-1:0]    a_ff, q_ff, c_ff;
   logic signed [MID_W-1:0]    a_in, q_in, c_in;

   // stage 1: offset from center; stage 2: products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oc_in[i] = OC_W'($signed(origin[i])) - OC_W'($signed(center[i]));
         dd_in[i] = DD_W'($signed(d_ff[0][i])) * DD_W'($signed(d_ff[0][i]));
         od_in[i] = OD_W'(oc_ff[i]) * OD_W'($signed(d_ff[0][i]));
         oo_in[i] = OO_W'(oc_ff[i]) * OO_W'(oc_ff[i]);
      end
      rr_in = RR_W'(r_ff) * RR_W'(r_ff);
   end

   // stage 3: dot products
   always_comb begin
      sa_in = SUM_W'(dd_ff[0]) + SUM_W'(dd_ff[1]) + SUM_W'(dd_ff[2]);
      sq_in = SUM_W'(od_ff[0]) + SUM_W'(od_ff[1]) + SUM_W'(od_ff[2]);
      sc_in = SUM_W'(oo_ff[0]) + SUM_W'(oo_ff[1]) + SUM_W'(oo_ff[2]) - SUM_W'(rr_ff);
   end

   // stage 4: drop the extra fraction bits and saturate
   always_comb begin
      a_in = sat_mid(CMP_W'(sa_ff >>> FRAC_BITS));
      q_in = sat_mid(CMP_W'(sq_ff >>> FRAC_BITS));
      c_in = sat_mid(CMP_W'(sc_ff >>> FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff[0] <= origin;
         d_ff[0] <= dir;
         for (int s = 1; s < 4; s++) begin
            o_ff[s] <= o_ff[s-1];
            d_ff[s] <= d_ff[s-1];
         end
         r_ff  <= radius;
         oc_ff <= oc_in;
         dd_ff <= dd_in;
         od_ff <= od_in;
         oo_ff <= oo_in;
         rr_ff <= rr_in;
         sa_ff <= sa_in;
         sq_ff <= sq_in;
         sc_ff <= sc_in;
         a_ff  <= a_in;
         q_ff  <= q_in;
         c_ff  <= c_in;
      end
   end

   // a ray with a <= 0 never hits
   assign ctl_out.valid = v_ff[3];
   assign ctl_out.hit   = ~a_ff[MID_W-1] & (a_ff != '0);
   assign a_out         = a_ff;
   assign q_out         = q_ff;
   assign c_out         = c_ff;
   assign origin_out    = o_ff[3];
   assign dir_out       = d_ff[3];

endmodule

// ----- design/rsi_disc.sv -----
// Reduced discriminant h = q*q - a*c from partial products of 30-bit and 32-bit halves, four stages.
module rsi_disc #(
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  rsi_pkg::ctl_type                  ctl_in,
   input  logic signed [rsi_pkg::MID_W-1:0]  a_in,
   input  logic signed [rsi_pkg::MID_W-1:0]  q_in,
   input  logic signed [rsi_pkg::MID_W-1:0]  c_in,
   input  logic [SIDE_W-1:0]                 side_in,
   output rsi_pkg::ctl_type                  ctl_out,
   output logic [rsi_pkg::H_W-1:0]           h_out,
   output logic [SIDE_W-1:0]                 side_out
);
   import rsi_pkg::*;

   ctl_type               ctl_ff [4];
   logic [SIDE_W-1:0]     side_ff [4];

   // stage 5 magnitudes
   logic [MAG_W-1:0]      qm_ff, am_ff, cm_ff;
   logic                  cneg_ff;
   // stage 6 partial products
   logic [2*HI_W-1:0]     qhh_ff, ahh_ff;
   logic [HI_W+LO_W-1:0]  qhl_ff, ahl_ff, alh_ff;
   logic [2*LO_W-1:0]     qll_ff, all_ff;
   logic                  cneg6_ff;
   // stage 7 full products
   logic [PP_W-1:0]       qsq_ff, ac_ff, qsq_in, ac_in;
   logic                  cneg7_ff;
   // stage 8 discriminant
   logic signed [H_W-1:0] h_ff, h_in;

   always_comb begin
      qsq_in = (PP_W'(qhh_ff) << (2 * LO_W)) + (PP_W'(qhl_ff) << (LO_W + 1))
             + PP_W'(qll_ff);
      ac_in  = (PP_W'(ahh_ff) << (2 * LO_W))
             + ((PP_W'(ahl_ff) + PP_W'(alh_ff)) << LO_W) + PP_W'(all_ff);
      // a > 0 on a hit, so the sign of a*c is the sign of c
      if (cneg7_ff) begin
         h_in = H_W'(qsq_ff) + H_W'(ac_ff);
      end else begin
         h_in = H_W'(qsq_ff) - H_W'(ac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < 4; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < 4; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         qm_ff    <= MAG_W'(q_in[MID_W-1] ? -q_in : q_in);
         am_ff    <= MAG_W'(a_in[MID_W-1] ? -a_in : a_in);
         cm_ff    <= MAG_W'(c_in[MID_W-1] ? -c_in : c_in);
         cneg_ff  <= c_in[MID_W-1];
         qhh_ff   <= (2*HI_W)'(qm_ff[MAG_W-1:LO_W]) * (2*HI_W)'(qm_ff[MAG_W-1:LO_W]);
         qhl_ff   <= (HI_W+LO_W)'(qm_ff[MAG_W-1:LO_W]) * (HI_W+LO_W)'(qm_ff[LO_W-1:0]);
         qll_ff   <= (2*LO_W)'(qm_ff[LO_W-1:0]) * (2*LO_W)'(qm_ff[LO_W-1:0]);
         ahh_ff   <= (2*HI_W)'(am_ff[MAG_W-1:LO_W]) * (2*HI_W)'(cm_ff[MAG_W-1:LO_W]);
         ahl_ff   <= (HI_W+LO_W)'(am_ff[MAG_W-1:LO_W]) * (HI_W+LO_W)'(cm_ff[LO_W-1:0]);
         alh_ff   <= (HI_W+LO_W)'(am_ff[LO_W-1:0]) * (HI_W+LO_W)'(cm_ff[MAG_W-1:LO_W]);
         all_ff   <= (2*LO_W)'(am_ff[LO_W-1:0]) * (2*LO_W)'(cm_ff[LO_W-1:0]);
         cneg6_ff <= cneg_ff;
         qsq_ff   <= qsq_in;
         ac_ff    <= ac_in;
         cneg7_ff <= cneg6_ff;
         h_ff     <= h_in;
      end
   end

   // a negative discriminant is a miss
   assign ctl_out.valid = ctl_ff[3].valid;
   assign ctl_out.hit   = ctl_ff[3].hit & ~h_ff[H_W-1];
   assign h_out         = h_ff;
   assign side_out      = side_ff[3];

endmodule

// ----- design/rsi_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module rsi_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  rsi_pkg::ctl_type                 ctl_in,
   input  logic [rsi_pkg::H_W-1:0]          h_in,
   input  logic [SIDE_W-1:0]                side_in,
   output rsi_pkg::ctl_type                 ctl_out,
   output logic [rsi_pkg::ROOT_W-1:0]       root_out,
   output logic [SIDE_W-1:0]                side_out
);
   import rsi_pkg::*;

   localparam int N     = ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int TMP_W = REM_W + 2;

   ctl_type            ctl_ff  [N];
   logic [SIDE_W-1:0]  side_ff [N];
   logic [H_W-1:0]     rad_ff  [N];
   logic [H_W-1:0]     rad_in  [N];
   logic [ROOT_W-1:0]  root_ff [N];
   logic [ROOT_W-1:0]  root_in [N];
   logic [REM_W-1:0]   rem_ff  [N];
   logic [REM_W-1:0]   rem_in  [N];

   // each stage brings down two radicand bits and tries the next root bit
   always_comb begin
      logic [H_W-1:0]    s_rad;
      logic [ROOT_W-1:0] s_root;
      logic [REM_W-1:0]  s_rem;
      logic [TMP_W-1:0]  t_rem;
      logic [TMP_W-1:0]  trial;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            s_rad  = h_in;
            s_root = '0;
            s_rem  = '0;
         end else begin
            s_rad  = rad_ff[k-1];
            s_root = root_ff[k-1];
            s_rem  = rem_ff[k-1];
         end
         t_rem = {s_rem, s_rad[H_W-1 -: 2]};
         trial = TMP_W'({s_root, 2'b01});
         if (t_rem >= trial) begin
            rem_in[k]  = REM_W'(t_rem - trial);
            root_in[k] = {s_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = REM_W'(t_rem);
            root_in[k] = {s_root[ROOT_W-2:0], 1'b0};
         end
         rad_in[k] = {s_rad[H_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < N; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign ctl_out  = ctl_ff[N-1];
   assign root_out = root_ff[N-1];
   assign side_out = side_ff[N-1];

endmodule

// ----- design/rsi_div.sv -----
// Root selection and pipelined restoring division t = floor((n << FRAC_BITS) / a).
module rsi_div #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32,
   parameter int SIDE_W      = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  rsi_pkg::ctl_type                  ctl_in,
   input  logic signed [rsi_pkg::MID_W-1:0]  q_in,
   input  logic signed [rsi_pkg::MID_W-1:0]  a_in,
   input  logic [rsi_pkg::ROOT_W-1:0]        root_in,
   input  logic [SIDE_W-1:0]                 side_in,
   output rsi_pkg::ctl_type                  ctl_out,
   output logic [COORD_WIDTH-1:0]            quot_out,
   output logic                              inexact_out,
   output logic                              ovf_out,
   output logic                              neg_out,
   output logic [SIDE_W-1:0]                 side_out
);
   import rsi_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int NUMER_W = MAGN_W + FRAC_BITS;
   localparam int TOP_W   = NUMER_W - CW;
   localparam int CMP_W   = (TOP_W > MID_W) ? TOP_W : MID_W;
   localparam int REM_W   = MID_W;
   localparam int D       = CW + 1;

   // stage A: both numerators
   ctl_type               ctl_a_ff;
   logic [SIDE_W-1:0]     side_a_ff;
   logic signed [NUM_W-1:0] n1_ff, n2_ff;
   logic [MID_W-1:0]      a_a_ff;
   // stage B: chosen numerator as sign and magnitude
   ctl_type               ctl_b_ff;
   logic [SIDE_W-1:0]     side_b_ff;
   logic [MAGN_W-1:0]     m_ff;
   logic                  neg_b_ff;
   logic [MID_W-1:0]      a_b_ff;
   logic signed [NUM_W-1:0] sel;
   // divider stages: overflow check, then one quotient bit each
   ctl_type               ctl_ff  [D];
   logic [SIDE_W-1:0]     side_ff [D];
   logic [MID_W-1:0]      a_ff    [D];
   logic                  neg_ff  [D];
   logic                  ovf_ff  [D];
   logic [REM_W-1:0]      rem_ff  [D];
   logic [REM_W-1:0]      rem_in  [D];
   logic [CW-1:0]         low_ff  [D];
   logic [CW-1:0]         low_in  [D];
   logic [CW-1:0]         quot_ff [D];
   logic [CW-1:0]         quot_in [D];
   logic                  ovf_in;
   logic [NUMER_W-1:0]    numer;

   // t1 >= 0 exactly when its numerator is; t1 <= t2 always, so a non-negative
   // t1 is the pick and otherwise t2
   assign sel = n1_ff[NUM_W-1] ? n2_ff : n1_ff;

   always_comb begin
      logic [REM_W-1:0] t;
      numer      = {m_ff, {FRAC_BITS{1'b0}}};
      ovf_in     = CMP_W'(numer >> CW) >= CMP_W'(a_b_ff);
      rem_in[0]  = REM_W'(numer >> CW);
      low_in[0]  = numer[CW-1:0];
      quot_in[0] = '0;
      for (int j = 1; j < D; j++) begin
         t = {rem_ff[j-1][REM_W-2:0], low_ff[j-1][CW-1]};
         if (t >= a_ff[j-1]) begin
            rem_in[j]  = t - a_ff[j-1];
            quot_in[j] = {quot_ff[j-1][CW-2:0], 1'b1};
         end else begin
            rem_in[j]  = t;
            quot_in[j] = {quot_ff[j-1][CW-2:0], 1'b0};
         end
         low_in[j] = {low_ff[j-1][CW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         for (int j = 0; j < D; j++) begin
            ctl_ff[j] <= '0;
         end
      end else if (en) begin
         ctl_a_ff  <= ctl_in;
         ctl_b_ff  <= ctl_a_ff;
         ctl_ff[0] <= ctl_b_ff;
         for (int j = 1; j < D; j++) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff  <= side_in;
         n1_ff      <= -NUM_W'(q_in) - NUM_W'(root_in);
         n2_ff      <= -NUM_W'(q_in) + NUM_W'(root_in);
         a_a_ff     <= a_in;
         side_b_ff  <= side_a_ff;
         neg_b_ff   <= sel[NUM_W-1];
         m_ff       <= MAGN_W'(sel[NUM_W-1] ? -sel : sel);
         a_b_ff     <= a_a_ff;
         side_ff[0] <= side_b_ff;
         a_ff[0]    <= a_b_ff;
         neg_ff[0]  <= neg_b_ff;
         ovf_ff[0]  <= ovf_in;
         for (int j = 1; j < D; j++) begin
            side_ff[j] <= side_ff[j-1];
            a_ff[j]    <= a_ff[j-1];
            neg_ff[j]  <= neg_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
         end
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
      end
   end

   assign ctl_out     = ctl_ff[D-1];
   assign quot_out    = quot_ff[D-1];
   assign inexact_out = rem_ff[D-1] != '0;
   assign ovf_out     = ovf_ff[D-1];
   assign neg_out     = neg_ff[D-1];
   assign side_out    = side_ff[D-1];

endmodule

// ----- sim/rsi_checker.sv -----
// Checker for the ray/sphere block: watches all three channels, predicts and compares.
module rsi_checker (
   input  logic clock,
   input  logic reset,
   rsi_csr_if   csr_bus,
   rsi_req_if   req_bus,
   rsi_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import rsi_pkg::*;

   localparam int FB = 16;
   localparam logic signed [127:0] LIM62 = (128'sd1 <<< 62) - 1;
   localparam logic signed [127:0] C_MAX = (128'sd1 <<< 31) - 1;
   localparam logic signed [127:0] C_MIN = -(128'sd1 <<< 31);

   typedef struct {
      logic              hit;
      logic signed [31:0] distance;
      logic signed [31:0] ix;
      logic signed [31:0] iy;
      logic signed [31:0] iz;
   } hit_word_type;

   hit_word_type hits_due[$];

   // sphere registers as last written
   logic signed [31:0] sph_cx, sph_cy, sph_cz;
   logic [30:0]        sph_r;

   function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
                                                 input logic signed [127:0] lo,
                                                 input logic signed [127:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // floor division, divisor positive
   function automatic logic signed [127:0] floor_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] dv);
      logic signed [127:0] qt;
      qt = n / dv;
      if ((n % dv) != 0 && n < 0) qt = qt - 1;
      return qt;
   endfunction

   function automatic hit_word_type predict_hit(input logic signed [31:0] o [3],
                                                input logic signed [31:0] d [3]);
      hit_word_type w;
      logic signed [127:0] oc [3];
      logic signed [127:0] sa, sq, sc, a, q, c, h, root, cand, t1, t2, t, ts, p;
      logic signed [127:0] ctr [3];
      logic signed [127:0] rr;
      w = '{hit: 1'b0, distance: '0, ix: '0, iy: '0, iz: '0};
      ctr[0] = sph_cx;
      ctr[1] = sph_cy;
      ctr[2] = sph_cz;
      rr = {97'd0, sph_r};
      sa = 0;
      sq = 0;
      sc = 0;
      for (int i = 0; i < 3; i++) begin
         oc[i] = 128'(o[i]) - ctr[i];
         sa = sa + 128'(d[i]) * 128'(d[i]);
         sq = sq + oc[i] * 128'(d[i]);
         sc = sc + oc[i] * oc[i];
      end
      sc = sc - rr * rr;
      a = clamp(sa >>> FB, -LIM62, LIM62);
      q = clamp(sq >>> FB, -LIM62, LIM62);
      c = clamp(sc >>> FB, -LIM62, LIM62);
      if (a <= 0) return w;
      h = q * q - a * c;
      if (h < 0) return w;
      // floor integer square root
      root = 0;
      for (int b = 62; b >= 0; b--) begin
         cand = root | (128'sd1 <<< b);
         if (cand * cand <= h) root = cand;
      end
      t1 = floor_div((-q - root) <<< FB, a);
      t2 = floor_div((-q + root) <<< FB, a);
      if (t1 >= 0 && (t1 < t2 || t2 < 0)) t = t1;
      else t = t2;
      ts = clamp(t, C_MIN, C_MAX);
      w.hit = 1'b1;
      w.distance = ts[31:0];
      p = clamp(((ts * 128'(d[0])) >>> FB) + 128'(o[0]), C_MIN, C_MAX);
      w.ix = p[31:0];
      p = clamp(((ts * 128'(d[1])) >>> FB) + 128'(o[1]), C_MIN, C_MAX);
      w.iy = p[31:0];
      p = clamp(((ts * 128'(d[2])) >>> FB) + 128'(o[2]), C_MIN, C_MAX);
      w.iz = p[31:0];
      return w;
   endfunction

   always @(posedge clock) begin
      hit_word_type want;
      logic signed [31:0] o [3];
      logic signed [31:0] d [3];
      if (reset) begin
         hits_due.delete();
         sph_cx = '0;
         sph_cy = '0;
         sph_cz = '0;
         sph_r = '0;
         fail_count = 0;
      end else begin
         // register writes
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_CENTER_X: sph_cx = csr_bus.data;
               REG_CENTER_Y: sph_cy = csr_bus.data;
               REG_CENTER_Z: sph_cz = csr_bus.data;
               REG_SPHERE_RADIUS: sph_r = csr_bus.data[30:0];
               default: ;
            endcase
         end
         // result words against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (hits_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word hit=%0b t=%0d", $realtime,
                           rsp_bus.hit, rsp_bus.hit_distance);
            end else begin
               want = hits_due.pop_front();
               if (rsp_bus.hit !== want.hit || rsp_bus.hit_distance !== want.distance ||
                   rsp_bus.impact_x !== want.ix || rsp_bus.impact_y !== want.iy ||
                   rsp_bus.impact_z !== want.iz) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch exp hit=%0b t=%0d p=(%0d,%0d,%0d)",
                              $realtime, want.hit, want.distance, want.ix, want.iy,
                              want.iz,
                              " got hit=%0b t=%0d p=(%0d,%0d,%0d)",
                              rsp_bus.hit, rsp_bus.hit_distance, rsp_bus.impact_x,
                              rsp_bus.impact_y, rsp_bus.impact_z);
               end
            end
         end
         // accepted rays
         if (req_bus.valid && req_bus.ready) begin
            o[0] = req_bus.origin_x;
            o[1] = req_bus.origin_y;
            o[2] = req_bus.origin_z;
            d[0] = req_bus.dir_x;
            d[1] = req_bus.dir_y;
            d[2] = req_bus.dir_z;
            hits_due.push_back(predict_hit(o, d));
         end
      end
      pending = hits_due.size();
   end

endmodule

// ----- sim/ray_sphere_intersection_top_tb.sv -----
// Stimulus and verdict for the ray/sphere intersection block.
module ray_sphere_intersection_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsi_pkg::*;

   localparam int ONE = 32'sh10000;
   localparam logic signed [31:0] SMAX = 32'sh7fffffff;
   localparam logic signed [31:0] SMIN = 32'sh80000000;
   localparam int LIMIT = 300000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   sent;
   int   cycles;
   logic steady;

   // center as last written, used only to aim rays
   logic signed [31:0] aim_x, aim_y, aim_z;

   rsi_csr_if #(32) csr_bus ();
   rsi_req_if #(32) req_bus ();
   rsi_rsp_if #(32) rsp_bus ();

   ray_sphere_intersection_top dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rsi_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("ray_sphere_intersection_top_tb: done, errors");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 28);
   end

   task automatic send_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 28) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.origin_x <= ox;
      req_bus.origin_y <= oy;
      req_bus.origin_z <= oz;
      req_bus.dir_x <= dx;
      req_bus.dir_y <= dy;
      req_bus.dir_z <= dz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // let the pipeline drain; the block makes one word per ray
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_sphere(input logic signed [31:0] x, y, z, input logic [31:0] r);
      drain();
      write_reg(REG_CENTER_X, x);
      write_reg(REG_CENTER_Y, y);
      write_reg(REG_CENTER_Z, z);
      write_reg(REG_SPHERE_RADIUS, r);
      aim_x = x;
      aim_y = y;
      aim_z = z;
   endtask

   // mostly rays aimed near the center, some raw noise
   task automatic random_rays(input int n);
      logic signed [31:0] off [3];
      int span;
      for (int k = 0; k < n; k++) begin
         steady = (sent >= 250 && sent < 340);
         if ($urandom_range(99) < 25) begin
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            span = 16 * ONE;
            for (int i = 0; i < 3; i++)
               off[i] = $signed($urandom_range(0, 2 * span)) - span;
            send_ray(aim_x + off[0], aim_y + off[1], aim_z + off[2],
                     -(off[0] >>> 2) + $signed($urandom_range(0, 32768)) - 16384,
                     -(off[1] >>> 2) + $signed($urandom_range(0, 32768)) - 16384,
                     -(off[2] >>> 2) + $signed($urandom_range(0, 32768)) - 16384);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      steady = 1'b0;
      sent = 0;
      cycles = 0;
      aim_x = '0;
      aim_y = '0;
      aim_z = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      req_bus.valid = 1'b0;
      req_bus.origin_x = '0;
      req_bus.origin_y = '0;
      req_bus.origin_z = '0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      req_bus.dir_z = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset sphere: zero radius at the origin
      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(ONE, ONE, ONE, 1, 1, 1);
      send_ray(0, 0, 0, 0, 0, ONE);
      send_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
      send_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
      send_ray(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
      send_ray(-1, -1, -1, -1, -1, -1);

      // unit sphere five units up z
      set_sphere(0, 0, 5 * ONE, ONE);
      send_ray(0, 0, 0, 0, 0, ONE);
      send_ray(0, 0, 5 * ONE, 0, 0, ONE);
      send_ray(0, 0, 0, 0, 0, -ONE);
      send_ray(ONE, 0, 0, 0, 0, ONE);
      send_ray(2 * ONE, 0, 0, 0, 0, ONE);
      send_ray(0, 0, 0, 0, ONE, 0);
      send_ray(0, 0, 0, 0, 0, 1);
      send_ray(0, 0, 0, 0, 0, SMAX);
      send_ray(0, 0, 0, 0, 0, 2);
      send_ray(SMIN, 0, 5 * ONE, SMAX, 0, 0);
      random_rays(100);

      // extreme sphere
      set_sphere(SMAX, SMIN, SMAX, 32'h7fffffff);
      send_ray(0, 0, 0, ONE, -ONE, ONE);
      send_ray(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
      send_ray(SMIN, SMAX, SMIN, 1, 0, 0);
      random_rays(80);

      set_sphere(SMIN, SMAX, SMIN, 0);
      send_ray(SMIN, SMAX, SMIN, ONE, 0, 0);
      random_rays(80);

      // ordinary spheres with random content
      for (int ph = 0; ph < 3; ph++) begin
         set_sphere($signed($urandom_range(0, 200 * ONE)) - 100 * ONE,
                    $signed($urandom_range(0, 200 * ONE)) - 100 * ONE,
                    $signed($urandom_range(0, 200 * ONE)) - 100 * ONE,
                    $urandom_range(0, 12 * ONE));
         random_rays(80);
      end

      drain();
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("ray_sphere_intersection_top_tb: done, clean");
      else
         $display("ray_sphere_intersection_top_tb: done, errors");
      $finish;
   end

endmodule

// ----- ray_sphere_intersection_top.f -----
design/rsi_pkg.sv
design/rsi_ifs.sv
design/rsi_quad.sv
design/rsi_disc.sv
design/rsi_sqrt.sv
design/rsi_div.sv
design/ray_sphere_intersection_top.sv
sim/rsi_checker.sv
sim/ray_sphere_intersection_top_tb.sv
